/* rtl/core/approximate_topk_cell_selector_defines.svh */
// assertion helpers for the cell selector
`ifndef APPROXIMATE_TOPK_CELL_SELECTOR_DEFINES_SVH
`define APPROXIMATE_TOPK_CELL_SELECTOR_DEFINES_SVH

// same-cycle implication
`define ATKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/atks_pkg.sv */
package atks_pkg;

  localparam int DIST_BITS       = 32;
  localparam int CELL_BITS       = 20;
  localparam int PTS_BITS        = 16;
  localparam int K_BITS          = 16;
  localparam int TOT_BITS        = 24;
  localparam int KEPT_BITS       = 9;
  localparam int RIDX_BITS       = 8;
  localparam int MODE_BITS       = 2;
  localparam int STORE_DEPTH_DEF = 256;
  localparam int PROD_BITS       = K_BITS + DIST_BITS;

  localparam logic [K_BITS-1:0]    K_RESET   = K_BITS'(100);
  localparam logic [TOT_BITS-1:0]  TOT_MAX   = '1;
  localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

  localparam logic [MODE_BITS-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [DIST_BITS-1:0] distance;
    logic [CELL_BITS-1:0] cell_id;
    logic [PTS_BITS-1:0]  point_count;
    logic [RIDX_BITS-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 store_full;
    logic [KEPT_BITS-1:0] kept_entries;
    logic [DIST_BITS-1:0] threshold;
    logic [TOT_BITS-1:0]  total_points;
    logic [DIST_BITS-1:0] entry_distance;
    logic [CELL_BITS-1:0] entry_cell;
    logic [PTS_BITS-1:0]  entry_points;
  } out_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [CELL_BITS-1:0] cell_id;
    logic [PTS_BITS-1:0]  pts;
  } ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_RESP, ST_MUL, ST_DIV, ST_PIV,
    ST_P1_RD, ST_P1_EV, ST_P2_RD, ST_P2_EV,
    ST_INS_CHK, ST_INS_EV, ST_INS_WR,
    ST_DROP_CHK, ST_DROP_EV, ST_COPY_RD, ST_COPY_EV
  } state_t;

endpackage

/* rtl/core/approximate_topk_cell_selector.sv */
// push, read, clear and status items pass from the start beat through ST_EXEC to ST_RESP, the result beat
// a push that triggers a partition first runs the multiply and the 48-step divider, then
// the pivot step, two scans of the entries, the insertion steps, the drops and the copy back
// busy stays high through the result beat; a new item is taken only in idle, after the result beat
// reset (rst_n low, synchronous): empty store, zero total, all-ones threshold, k = 100
// results are shown for one cycle on out_valid; the receiver cannot stall
module approximate_topk_cell_selector
  import atks_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [K_BITS-1:0] cfg_wdata
);

  `include "approximate_topk_cell_selector_defines.svh"

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int DCW = $clog2(PROD_BITS);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  ent_t main_mem [STORE_DEPTH];
  ent_t tmp_mem  [STORE_DEPTH];
  ent_t main_rd_r, tmp_rd_r;

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [K_BITS-1:0]     k_r, k_nxt;
  logic [DIST_BITS-1:0]  thr_r, thr_nxt, min_r, min_nxt, pivot_r, pivot_nxt;
  logic [TOT_BITS-1:0]   tot_r, tot_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  acc_r, acc_nxt, full_r, full_nxt, evld_r, evld_nxt;
  logic [PROD_BITS-1:0]  qd_r, qd_nxt;
  logic [TOT_BITS:0]     rem_r, rem_nxt;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt;
  logic [CW-1:0]         front_r, front_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]         pos_r, pos_nxt, tail_r, tail_nxt, newn_r, newn_nxt;
  ent_t                  key_r, key_nxt;

  logic [AW-1:0] main_raddr, tmp_raddr, main_waddr, tmp_waddr;
  logic          main_we, tmp_we;
  ent_t          main_wdata, tmp_wdata;

  logic [TOT_BITS:0]    sum_w, rem_sh;
  logic [TOT_BITS-1:0]  tot_new;
  logic [CW-1:0]        fill_new;
  logic [TOT_BITS+2:0]  tot5, k7;
  logic [DIST_BITS-1:0] diff;
  logic                 ge;
  ent_t                 new_ent;

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    main_rd_r <= main_mem[main_raddr];
  end

  always_ff @(posedge clk) begin
    if (tmp_we) begin
      tmp_mem[tmp_waddr] <= tmp_wdata;
    end
    tmp_rd_r <= tmp_mem[tmp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= K_RESET;
      thr_r   <= DIST_ONES;
      min_r   <= DIST_ONES;
      tot_r   <= '0;
      fill_r  <= '0;
      acc_r   <= 1'b0;
      full_r  <= 1'b0;
      evld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      thr_r   <= thr_nxt;
      min_r   <= min_nxt;
      tot_r   <= tot_nxt;
      fill_r  <= fill_nxt;
      acc_r   <= acc_nxt;
      full_r  <= full_nxt;
      evld_r  <= evld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    pivot_r <= pivot_nxt;
    qd_r    <= qd_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    front_r <= front_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    pos_r   <= pos_nxt;
    tail_r  <= tail_nxt;
    newn_r  <= newn_nxt;
    key_r   <= key_nxt;
  end

  assign sum_w    = {1'b0, tot_r} + (TOT_BITS+1)'(item_r.point_count);
  assign tot_new  = sum_w[TOT_BITS] ? TOT_MAX : sum_w[TOT_BITS-1:0];
  assign fill_new = fill_r + CW'(1);
  assign tot5     = ({3'b0, tot_new} << 2) + {3'b0, tot_new};
  assign k7       = (TOT_BITS+3)'({k_r, 3'b0}) - (TOT_BITS+3)'(k_r);
  assign diff     = (thr_r >= min_r) ? thr_r - min_r : '0;
  assign rem_sh   = {rem_r[TOT_BITS-1:0], qd_r[PROD_BITS-1]};
  assign ge       = rem_sh >= {1'b0, tot_r};
  assign new_ent  = '{distance: item_r.distance, cell_id: item_r.cell_id,
                      pts: item_r.point_count};

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    k_nxt      = cfg_we ? cfg_wdata : k_r;
    thr_nxt    = thr_r;
    min_nxt    = min_r;
    tot_nxt    = tot_r;
    fill_nxt   = fill_r;
    acc_nxt    = acc_r;
    full_nxt   = full_r;
    evld_nxt   = evld_r;
    pivot_nxt  = pivot_r;
    qd_nxt     = qd_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    front_nxt  = front_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    tail_nxt   = tail_r;
    newn_nxt   = newn_r;
    key_nxt    = key_r;
    main_raddr = AW'(item_r.read_index);
    tmp_raddr  = AW'(pos_r - CW'(1));
    main_we    = 1'b0;
    main_waddr = AW'(fill_r);
    main_wdata = new_ent;
    tmp_we     = 1'b0;
    tmp_waddr  = AW'(pos_r);
    tmp_wdata  = key_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          acc_nxt   = 1'b0;
          full_nxt  = 1'b0;
          evld_nxt  = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        case (item_r.mode)
          MODE_PUSH: begin
            if (item_r.distance <= thr_r) begin
              if (fill_r >= DEPTH_C) begin
                full_nxt = 1'b1;
              end else begin
                main_we  = 1'b1;
                acc_nxt  = 1'b1;
                fill_nxt = fill_new;
                tot_nxt  = tot_new;
                if (item_r.distance < min_r) begin
                  min_nxt = item_r.distance;
                end
                if ((tot5 >= k7 || fill_new >= DEPTH_C) && tot_new >= TOT_BITS'(k_r)) begin
                  state_nxt = ST_MUL;
                end
              end
            end
          end
          MODE_READ: begin
            evld_nxt = 16'(item_r.read_index) < 16'(fill_r);
          end
          MODE_CLEAR: begin
            fill_nxt = '0;
            tot_nxt  = '0;
            thr_nxt  = DIST_ONES;
            min_nxt  = DIST_ONES;
          end
          default: begin
          end
        endcase
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        qd_nxt   = PROD_BITS'(k_r) * PROD_BITS'(diff);
        rem_nxt  = '0;
        dcnt_nxt = '0;
        if (tot_r == '0) begin
          qd_nxt    = '0;
          state_nxt = ST_PIV;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? rem_sh - {1'b0, tot_r} : rem_sh;
        qd_nxt   = {qd_r[PROD_BITS-2:0], ge};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(PROD_BITS - 1)) begin
          state_nxt = ST_PIV;
        end
      end
      ST_PIV: begin
        pivot_nxt = min_r + qd_r[DIST_BITS-1:0];
        i_nxt     = '0;
        front_nxt = '0;
        state_nxt = ST_P1_RD;
      end
      ST_P1_RD: begin
        main_raddr = AW'(i_r);
        state_nxt  = ST_P1_EV;
      end
      ST_P1_EV: begin
        if (main_rd_r.distance <= pivot_r) begin
          tmp_we    = 1'b1;
          tmp_waddr = AW'(front_r);
          tmp_wdata = main_rd_r;
          front_nxt = front_r + CW'(1);
        end
        if (i_r + CW'(1) == fill_r) begin
          i_nxt     = '0;
          j_nxt     = front_nxt;
          state_nxt = ST_P2_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_P1_RD;
        end
      end
      ST_P2_RD: begin
        main_raddr = AW'(i_r);
        state_nxt  = ST_P2_EV;
      end
      ST_P2_EV: begin
        if (main_rd_r.distance > pivot_r) begin
          key_nxt   = main_rd_r;
          pos_nxt   = j_r;
          state_nxt = ST_INS_CHK;
        end else if (i_r + CW'(1) == fill_r) begin
          tail_nxt  = fill_r - CW'(1);
          state_nxt = ST_DROP_CHK;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_P2_RD;
        end
      end
      ST_INS_CHK: begin
        state_nxt = (pos_r == front_r) ? ST_INS_WR : ST_INS_EV;
      end
      ST_INS_EV: begin
        if (key_r < tmp_rd_r) begin
          tmp_we    = 1'b1;
          tmp_wdata = tmp_rd_r;
          pos_nxt   = pos_r - CW'(1);
          state_nxt = ST_INS_CHK;
        end else begin
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        tmp_we = 1'b1;
        j_nxt  = j_r + CW'(1);
        if (i_r + CW'(1) == fill_r) begin
          tail_nxt  = fill_r - CW'(1);
          state_nxt = ST_DROP_CHK;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_P2_RD;
        end
      end
      ST_DROP_CHK: begin
        tmp_raddr = AW'(tail_r);
        i_nxt     = '0;
        if (tail_r > front_r) begin
          state_nxt = ST_DROP_EV;
        end else begin
          thr_nxt  = pivot_r;
          newn_nxt = front_r;
          if (front_r == '0) begin
            fill_nxt  = '0;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_COPY_RD;
          end
        end
      end
      ST_DROP_EV: begin
        if ({1'b0, tot_r} >= (TOT_BITS+1)'(k_r) + (TOT_BITS+1)'(tmp_rd_r.pts)) begin
          tot_nxt   = tot_r - TOT_BITS'(tmp_rd_r.pts);
          tail_nxt  = tail_r - CW'(1);
          state_nxt = ST_DROP_CHK;
        end else begin
          thr_nxt   = tmp_rd_r.distance;
          newn_nxt  = tail_r + CW'(1);
          state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        tmp_raddr = AW'(i_r);
        state_nxt = ST_COPY_EV;
      end
      ST_COPY_EV: begin
        main_we    = 1'b1;
        main_waddr = AW'(i_r);
        main_wdata = tmp_rd_r;
        if (i_r + CW'(1) == newn_r) begin
          fill_nxt  = newn_r;
          state_nxt = ST_RESP;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_COPY_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = state_r == ST_RESP;

  always_comb begin
    out_item.accepted       = acc_r;
    out_item.store_full     = full_r;
    out_item.kept_entries   = KEPT_BITS'(fill_r);
    out_item.threshold      = thr_r;
    out_item.total_points   = tot_r;
    out_item.entry_distance = evld_r ? main_rd_r.distance : '0;
    out_item.entry_cell     = evld_r ? main_rd_r.cell_id  : '0;
    out_item.entry_points   = evld_r ? main_rd_r.pts      : '0;
  end

  `ATKS_ASSERT_NOW(a_resp_busy, out_valid, busy, "result beat while idle")
  `ATKS_ASSERT_NOW(a_fill_range, 1'b1, fill_r <= DEPTH_C, "fill beyond store depth")
  `ATKS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not start work")
  `ATKS_ASSERT_NEXT(a_resp_idle, out_valid, !busy && !out_valid, "result beat not followed by idle")
  `ATKS_ASSERT_NOW(a_acc_full, out_valid, !(out_item.accepted && out_item.store_full), "stored and full")

endmodule

/* bench/approximate_topk_cell_selector_tb.sv */
`timescale 1ns / 100ps

module approximate_topk_cell_selector_tb;
  import atks_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam longint unsigned CYCLE_LIMIT = 600000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [K_BITS-1:0] cfg_wdata = '0;

  approximate_topk_cell_selector uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the cell store
  bit [DIST_BITS-1:0] sh_dist [DEPTH];
  bit [CELL_BITS-1:0] sh_cell [DEPTH];
  bit [PTS_BITS-1:0]  sh_pts  [DEPTH];
  int unsigned        sh_fill = 0;
  longint unsigned    sh_total = 0;
  longint unsigned    sh_thr = DIST_ONES;
  longint unsigned    sh_min = DIST_ONES;
  longint unsigned    sh_k = K_RESET;

  in_item_t  pend_q[$];
  out_item_t expected_q[$];
  in_item_t  cur;
  int        gap = 0;
  bit        idle_on = 1'b1;
  bit        drain_req = 1'b0;
  int        mismatches = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        pushes_kept = 0;
  int        full_hits = 0;
  int        settings_run = 0;
  longint unsigned cycles = 0;

  function automatic bit ent_less(int a, int b);
    if (sh_dist[a] != sh_dist[b]) return sh_dist[a] < sh_dist[b];
    if (sh_cell[a] != sh_cell[b]) return sh_cell[a] < sh_cell[b];
    return sh_pts[a] < sh_pts[b];
  endfunction

  function automatic int split_tail();
    longint unsigned total, diff, pivot, q, r, cnt;
    bit [DIST_BITS-1:0] td [DEPTH];
    bit [CELL_BITS-1:0] tc [DEPTH];
    bit [PTS_BITS-1:0]  tp [DEPTH];
    bit [DIST_BITS-1:0] hd;
    bit [CELL_BITS-1:0] hc;
    bit [PTS_BITS-1:0]  hp;
    int front, j, idx;
    total = sh_total;
    if (total < sh_k || sh_fill == 0) return sh_fill;
    diff = (sh_thr >= sh_min) ? sh_thr - sh_min : 0;
    if (total == 0) pivot = sh_min;
    else begin
      q = diff / total;
      r = diff % total;
      pivot = sh_min + sh_k * q + (sh_k * r) / total;
    end
    front = 0;
    for (int i = 0; i < sh_fill; i++)
      if (sh_dist[i] <= pivot) begin
        td[front] = sh_dist[i]; tc[front] = sh_cell[i]; tp[front] = sh_pts[i];
        front++;
      end
    j = front;
    for (int i = 0; i < sh_fill; i++)
      if (sh_dist[i] > pivot) begin
        td[j] = sh_dist[i]; tc[j] = sh_cell[i]; tp[j] = sh_pts[i];
        j++;
      end
    for (int i = 0; i < sh_fill; i++) begin
      sh_dist[i] = td[i]; sh_cell[i] = tc[i]; sh_pts[i] = tp[i];
    end
    for (int i = front + 1; i < sh_fill; i++)
      for (int m = i; m > front && ent_less(m, m - 1); m--) begin
        hd = sh_dist[m]; hc = sh_cell[m]; hp = sh_pts[m];
        sh_dist[m] = sh_dist[m-1]; sh_cell[m] = sh_cell[m-1]; sh_pts[m] = sh_pts[m-1];
        sh_dist[m-1] = hd; sh_cell[m-1] = hc; sh_pts[m-1] = hp;
      end
    idx = sh_fill - 1;
    while (idx > front) begin
      cnt = sh_pts[idx];
      if (total >= sh_k + cnt) begin
        total -= cnt;
        idx--;
      end else begin
        sh_thr = sh_dist[idx];
        sh_total = total;
        return idx + 1;
      end
    end
    sh_total = total;
    sh_thr = pivot & 64'hFFFF_FFFF;
    return front;
  endfunction

  function automatic out_item_t selector_result(in_item_t it);
    out_item_t o;
    longint unsigned t;
    o = '0;
    case (it.mode)
      MODE_PUSH: begin
        if (it.distance <= sh_thr) begin
          if (sh_fill >= DEPTH) begin
            o.store_full = 1'b1;
            full_hits++;
          end else begin
            sh_dist[sh_fill] = it.distance;
            sh_cell[sh_fill] = it.cell_id;
            sh_pts[sh_fill] = it.point_count;
            sh_fill++;
            if (it.distance < sh_min) sh_min = it.distance;
            t = sh_total + it.point_count;
            sh_total = (t > TOT_MAX) ? TOT_MAX : t;
            o.accepted = 1'b1;
            pushes_kept++;
            if (sh_total * 5 >= sh_k * 7 || sh_fill >= DEPTH) sh_fill = split_tail();
          end
        end
      end
      MODE_READ: begin
        if (it.read_index < sh_fill) begin
          o.entry_distance = sh_dist[it.read_index];
          o.entry_cell = sh_cell[it.read_index];
          o.entry_points = sh_pts[it.read_index];
        end
      end
      MODE_CLEAR: begin
        sh_fill = 0;
        sh_total = 0;
        sh_thr = DIST_ONES;
        sh_min = DIST_ONES;
      end
      default: ;
    endcase
    o.kept_entries = KEPT_BITS'(sh_fill);
    o.threshold = DIST_BITS'(sh_thr);
    o.total_points = TOT_BITS'(sh_total);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    bit nxt;
    if (rst_n) begin
      nxt = start;
      if (start && !busy) begin
        expected_q.push_back(selector_result(cur));
        beats_in++;
        nxt = 1'b0;
      end
      if (!nxt) begin
        if (gap > 0) gap--;
        else if (drain_req) begin
          if (expected_q.size() == 0) drain_req = 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_item <= cur;
          nxt = 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
        end
      end
      start <= nxt;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", out_item);
      end else begin
        e = expected_q.pop_front();
        if (out_item.accepted !== e.accepted || out_item.store_full !== e.store_full ||
            out_item.kept_entries !== e.kept_entries || out_item.threshold !== e.threshold ||
            out_item.total_points !== e.total_points ||
            out_item.entry_distance !== e.entry_distance ||
            out_item.entry_cell !== e.entry_cell || out_item.entry_points !== e.entry_points)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at beat %0d:\n  exp %p\n  got %p", beats_out, e, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] m, logic [31:0] d, logic [19:0] c,
                                  logic [15:0] p, logic [7:0] r);
    in_item_t it;
    it.mode = m; it.distance = d; it.cell_id = c; it.point_count = p; it.read_index = r;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int sel;
    logic [31:0] d;
    logic [15:0] p;
    sel = $urandom_range(0, 99);
    d = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5000);
    case ($urandom_range(0, 5))
      0: p = 16'd0;
      1: p = 16'hFFFF;
      2: p = $urandom();
      default: p = $urandom_range(0, 60);
    endcase
    if (sel < 72) return mk(MODE_PUSH, d, $urandom(), p, $urandom());
    if (sel < 92)
      return mk(MODE_READ, $urandom(), $urandom(), $urandom(),
                ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 12));
    if (sel < 97) return mk(2'd3, $urandom(), $urandom(), $urandom(), $urandom());
    return mk(MODE_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  task automatic wait_idle();
    do begin
      while (pend_q.size() != 0 || start || busy || expected_q.size() != 0) @(posedge clk);
      repeat (5) @(posedge clk);
    end while (pend_q.size() != 0 || start || busy || expected_q.size() != 0);
  endtask

  task automatic write_k(logic [K_BITS-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sh_k = v;
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  logic [K_BITS-1:0] k_list [6];

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of k, extremes of the fields
    pend_q.push_back(mk(MODE_READ, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_PUSH, 32'd0, 20'd0, 16'd0, 8'd0));
    pend_q.push_back(mk(MODE_PUSH, 32'd40, 20'hFFFFF, 16'd30, 8'hFF));
    pend_q.push_back(mk(MODE_READ, 0, 0, 0, 8'd1));
    pend_q.push_back(mk(MODE_READ, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF));
    pend_q.push_back(mk(MODE_PUSH, 32'hFFFFFFFF, 20'h12345, 16'hFFFF, 8'd0));
    pend_q.push_back(mk(2'd3, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF));
    pend_q.push_back(mk(MODE_READ, 0, 0, 0, 8'd0));
    pend_q.push_back(mk(MODE_PUSH, 32'hFFFFFFFF, 20'd7, 16'd5, 8'd0));
    pend_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));

    // largest k: fill the store with empty cells, then overflow it
    write_k(16'hFFFF);
    for (int i = 0; i < DEPTH; i++)
      pend_q.push_back(mk(MODE_PUSH, $urandom_range(0, 999), $urandom(), 16'd0, 0));
    pend_q.push_back(mk(MODE_PUSH, 32'd5, 20'd1, 16'd9, 0));
    pend_q.push_back(mk(MODE_READ, 0, 0, 0, 8'hFF));
    pend_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));

    // smallest k: two pushes, each starting a partition, then a read
    write_k(16'd1);
    pend_q.push_back(mk(MODE_PUSH, 32'd10, 20'd1, 16'd3, 0));
    pend_q.push_back(mk(MODE_PUSH, 32'd20, 20'd2, 16'd3, 0));
    pend_q.push_back(mk(MODE_READ, 0, 0, 0, 8'd0));
    pend_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));

    k_list = '{16'd100, 16'd1, 16'hFFFF, 16'd7, 16'($urandom_range(2, 3000)), 16'd250};
    foreach (k_list[s]) begin
      write_k(k_list[s]);
      if (s == 5) idle_on = 1'b0;
      for (int n = 0; n < 330; n++) begin
        pend_q.push_back(rand_item());
        if (s == 2 && n == 150) begin
          while (pend_q.size() != 0) @(posedge clk);
          drain_req = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d beats sent over %0d k settings, %0d results checked", beats_in,
             settings_run, beats_out);
    $display("%0d cells kept, %0d pushes bounced by a full store", pushes_kept, full_hits);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
